// ===== hdl/sfr_pkg.sv =====
// Package for the serial frame receiver
// Holds the frame constants, status codes and the result item type; no dependencies
`timescale 1ns / 1ps

package sfr_pkg;

    // default largest payload, checksum byte included
    localparam int MAX_PAYLOAD_DEF = 32;

    // frame delimiters and command limit
    localparam logic [7:0] HEADER_BYTE   = 8'h55;
    localparam logic [7:0] COMMAND_LIMIT = 8'h03;
    localparam logic [7:0] TAIL_BYTE     = 8'hAA;

    // per-item status codes
    localparam logic [1:0] ST_HUNT  = 2'd0;
    localparam logic [1:0] ST_TAKEN = 2'd1;
    localparam logic [1:0] ST_VALID = 2'd2;
    localparam logic [1:0] ST_DROP  = 2'd3;

    // one result item
    typedef struct packed {
        logic [5:0] slot;
        logic [7:0] data_byte;
        logic [1:0] status;
        logic [1:0] frame_command;
        logic [5:0] frame_length;
    } t_result;

endpackage

// ===== hdl/serial_frame_receiver_core.sv =====
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle; the input register, the parser and the result
// register form a two-register pipeline that advances whenever the result slot frees.
// Reset: synchronous active-low reset empties both registers and returns the parser
// to hunting for a header at slot 0.
// Top level of the serial frame receiver; depends on sfr_pkg and sfr_parse
`timescale 1ns / 1ps

module serial_frame_receiver_core
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [5:0] o_slot,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_status,
    output logic [1:0] o_frame_command,
    output logic [5:0] o_frame_length
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    result;
    logic       advance;

    // pipeline moves when the input register holds an item and the result slot frees
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    sfr_parse #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_byte  (r_in_byte),
        .o_result(result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_slot          = r_out.slot;
    assign o_data_byte     = r_out.data_byte;
    assign o_status        = r_out.status;
    assign o_frame_command = r_out.frame_command;
    assign o_frame_length  = r_out.frame_length;

endmodule

// ===== hdl/sfr_parse.sv =====
// Frame parser: holds the frame tracking state and classifies one byte per cycle while enabled
// Depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_parse
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    localparam int POS_W = $clog2(MAX_PAYLOAD + 4);
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [POS_W-1:0] POS_HEADER  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_COMMAND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LENGTH  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(3);
    localparam logic [7:0]       MAX_LEN_B   = 8'(MAX_PAYLOAD);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_plen, n_plen;
    logic [7:0]       r_sum, n_sum;
    logic [1:0]       r_cmd, n_cmd;

    logic [POS_W-1:0] tail_pos;
    logic [POS_W-1:0] pos_inc;
    logic [7:0]       sum_add;
    logic [1:0]       status;
    logic [1:0]       fcmd;
    logic [5:0]       flen;

    assign tail_pos = POS_W'(r_plen) + POS_PAYLOAD;
    assign pos_inc  = r_pos + POS_W'(1);
    assign sum_add  = r_sum + i_byte;

    // next state and status for the byte in the input register
    always_comb begin
        n_pos  = r_pos;
        n_plen = r_plen;
        n_sum  = r_sum;
        n_cmd  = r_cmd;
        status = ST_TAKEN;
        fcmd   = 2'd0;
        flen   = 6'd0;
        if (r_pos == POS_HEADER) begin
            if (i_byte == HEADER_BYTE) begin
                n_pos = POS_COMMAND;
            end else begin
                status = ST_HUNT;
            end
        end else if (r_pos == POS_COMMAND) begin
            if (i_byte < COMMAND_LIMIT) begin
                n_cmd = i_byte[1:0];
                n_sum = i_byte;
                n_pos = POS_LENGTH;
            end else begin
                status = ST_DROP;
                n_pos  = POS_HEADER;
            end
        end else if (r_pos == POS_LENGTH) begin
            if (i_byte != 8'd0 && i_byte <= MAX_LEN_B) begin
                n_plen = LEN_W'(i_byte);
                n_sum  = sum_add;
                n_pos  = POS_PAYLOAD;
            end else begin
                status = ST_DROP;
                n_pos  = POS_HEADER;
            end
        end else if (r_pos >= tail_pos) begin
            // tail slot
            if (i_byte == TAIL_BYTE) begin
                status = ST_VALID;
                fcmd   = r_cmd;
                flen   = 6'(r_plen);
            end else begin
                status = ST_DROP;
            end
            n_pos = POS_HEADER;
        end else begin
            // payload byte, the last one carries the checksum
            n_sum = sum_add;
            n_pos = pos_inc;
            if (pos_inc == tail_pos && sum_add != 8'd0) begin
                status = ST_DROP;
                n_pos  = POS_HEADER;
            end
        end
    end

    // result item for the current byte
    always_comb begin
        o_result.slot          = 6'(r_pos);
        o_result.data_byte     = i_byte;
        o_result.status        = status;
        o_result.frame_command = fcmd;
        o_result.frame_length  = flen;
    end

    // frame tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_plen <= '0;
            r_sum  <= '0;
            r_cmd  <= '0;
        end else if (i_en) begin
            r_pos  <= n_pos;
            r_plen <= n_plen;
            r_sum  <= n_sum;
            r_cmd  <= n_cmd;
        end
    end

endmodule

// ===== hdl/sfr_checker.sv =====
// Port-level checks for the serial frame receiver, bound to the top level
// Depends on sfr_pkg and serial_frame_receiver_core
`timescale 1ns / 1ps

module sfr_checker
    import sfr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [5:0] o_slot,
    input logic [7:0] o_data_byte,
    input logic [1:0] o_status,
    input logic [1:0] o_frame_command,
    input logic [5:0] o_frame_length
);

    // a stalled result item stays valid and keeps its status and slot
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_slot))
        else $error("result item changed while stalled");

    // hunting happens only at the header slot
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_HUNT |-> o_slot == 6'd0)
        else $error("hunting status away from slot 0");

    // a byte taken at the header slot is the header
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_TAKEN && o_slot == 6'd0 |-> o_data_byte == HEADER_BYTE)
        else $error("non-header byte taken at slot 0");

    // a completed frame ends on the tail byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_VALID |-> o_data_byte == TAIL_BYTE && o_frame_length != 6'd0)
        else $error("valid frame without tail byte or with zero length");

    // frame fields stay zero unless a frame completes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_VALID |-> o_frame_command == 2'd0 && o_frame_length == 6'd0)
        else $error("frame fields set without a completed frame");

endmodule

bind serial_frame_receiver_core sfr_checker u_sfr_checker (.*);
